[sv/sha0_message_digest_assert.svh]
// ----------------------------------------------------------------------------
// SHA-0 digest assertion macros
// Property wrappers shared by the digest block, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA0_MESSAGE_DIGEST_ASSERT_SVH
`define SHA0_MESSAGE_DIGEST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SHA0_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHA0_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/sha0_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-0 digest package
// Shared types, round constants and initial chaining value.
// ----------------------------------------------------------------------------
package sha0_pkg;

    localparam int CHAIN_WORDS = 5;
    localparam int BLOCK_WORDS = 16;

    typedef logic [31:0] t_word;
    typedef logic [CHAIN_WORDS-1:0][31:0] t_chain;
    typedef logic [6:0] t_rnd;
    typedef logic [3:0] t_pos;
    typedef logic [2:0] t_out_idx;

    localparam t_rnd ROUND_LAST = 7'd79;
    localparam t_rnd ROUND_P1   = 7'd20;
    localparam t_rnd ROUND_P2   = 7'd40;
    localparam t_rnd ROUND_P3   = 7'd60;

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    // entry 0 is the most significant digest word
    localparam t_chain CHAIN_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                   32'hEFCDAB89, 32'h67452301};

    localparam t_word    PAD_ONLY     = 32'h8000_0000;
    localparam t_pos     POS_LAST     = 4'd15;
    localparam t_pos     POS_LEN_HI   = 4'd14;
    localparam t_out_idx OUT_LAST     = 3'd4;
    localparam logic [2:0] BYTES_FULL = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_PAD,
        PH_ZERO,
        PH_LEN_LO,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic  push;
        logic  step;
        t_word data;
    } t_buf_ctl;

    typedef struct packed {
        logic init;
        logic load;
        logic step;
        logic add;
    } t_core_ctl;

endpackage

[sv/sha0_sched.sv]
// ----------------------------------------------------------------------------
// SHA-0 block buffer and message schedule
// Sixteen-word shift line: loads the block, then expands the schedule one
// word per round without rotate.
// ----------------------------------------------------------------------------
module sha0_sched (
    input  logic              i_clk,
    input  sha0_pkg::t_buf_ctl i_ctl,
    output sha0_pkg::t_word   o_w
);
    import sha0_pkg::*;

    t_word r_w [BLOCK_WORDS];
    t_word n_expand;

    // window holds w[t] .. w[t+15], oldest at entry 0
    assign n_expand = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign o_w      = r_w[0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || i_ctl.step) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= i_ctl.push ? i_ctl.data : n_expand;
        end
    end

endmodule

[sv/sha0_round.sv]
// ----------------------------------------------------------------------------
// SHA-0 round unit
// Working registers a..e, one round per step, and the chaining words.
// ----------------------------------------------------------------------------
module sha0_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha0_pkg::t_core_ctl i_ctl,
    input  sha0_pkg::t_rnd      i_round,
    input  sha0_pkg::t_word     i_w,
    output sha0_pkg::t_chain    o_chain
);
    import sha0_pkg::*;

    t_chain r_chain;
    t_word  r_a, r_b, r_c, r_d, r_e;
    t_word  n_f, n_k, n_t;

    always_comb begin
        if (i_round < ROUND_P1) begin
            n_f = (r_b & r_c) | (~r_b & r_d);
            n_k = K0;
        end else if (i_round < ROUND_P2) begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = K1;
        end else if (i_round < ROUND_P3) begin
            n_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            n_k = K2;
        end else begin
            n_f = r_b ^ r_c ^ r_d;
            n_k = K3;
        end
        n_t = {r_a[26:0], r_a[31:27]} + n_f + r_e + i_w + n_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_chain <= CHAIN_IV;
        end else if (i_ctl.add) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_ctl.step) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= n_t;
        end
    end

    assign o_chain = r_chain;

endmodule

[sv/sha0_message_digest.sv]
// ----------------------------------------------------------------------------
// SHA-0 message digest
// A word is taken while idle; the word that completes a block holds the
// input through the load on accept, 80 rounds on one shared round adder
// and the add. A final word adds the fill of pad, zero and length words
// into one or two padding blocks, each with its rounds and add, then 5
// digest items, one per cycle when not stalled.
// Synchronous active-low reset restores the initial chaining value, zero
// bit count and word position; the block buffer is not cleared.
// ----------------------------------------------------------------------------
module sha0_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_byte_count,
    input  logic        i_final_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_run_end
);
    import sha0_pkg::*;

    t_state      r_state, n_state;
    t_pos        r_pos, n_pos;
    logic [63:0] r_len, n_len;
    t_phase      r_phase, n_phase;
    t_rnd        r_rnd, n_rnd;
    t_out_idx    r_out, n_out;
    logic        r_final, n_final;
    t_word       r_pad, n_pad;

    t_buf_ctl    buf_ctl;
    t_core_ctl   core_ctl;
    t_word       sched_w;
    t_chain      chain;
    logic [2:0]  nbytes;
    t_word       pad_word;

    sha0_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (buf_ctl),
        .o_w   (sched_w)
    );

    sha0_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_round (r_rnd),
        .i_w     (sched_w),
        .o_chain (chain)
    );

    // saturate the byte count and build the padded last word
    always_comb begin
        nbytes = (i_byte_count > BYTES_FULL) ? BYTES_FULL : i_byte_count;
        case (nbytes)
            3'd0:    pad_word = PAD_ONLY;
            3'd1:    pad_word = {i_message_word[31:24], 24'h80_0000};
            3'd2:    pad_word = {i_message_word[31:16], 16'h8000};
            3'd3:    pad_word = {i_message_word[31:8], 8'h80};
            default: pad_word = PAD_ONLY;
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = chain[r_out];
    assign o_word_number = r_out;
    assign o_run_end     = (r_out == OUT_LAST);

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_len    = r_len;
        n_phase  = r_phase;
        n_rnd    = r_rnd;
        n_out    = r_out;
        n_final  = r_final;
        n_pad    = r_pad;
        buf_ctl  = '0;
        core_ctl = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (!i_final_word) begin
                        buf_ctl.push = 1'b1;
                        buf_ctl.data = i_message_word;
                        n_len        = r_len + 64'd32;
                    end else begin
                        n_final = 1'b1;
                        n_phase = PH_PAD;
                        n_state = S_FILL;
                        n_len   = r_len + 64'({nbytes, 3'b000});
                        if (nbytes == BYTES_FULL) begin
                            buf_ctl.push = 1'b1;
                            buf_ctl.data = i_message_word;
                            n_pad        = PAD_ONLY;
                        end else begin
                            n_pad = pad_word;
                        end
                    end
                end
            end
            S_FILL: begin
                buf_ctl.push = 1'b1;
                case (r_phase)
                    PH_PAD: begin
                        buf_ctl.data = r_pad;
                        n_phase      = PH_ZERO;
                    end
                    PH_ZERO: begin
                        if (r_pos == POS_LEN_HI) begin
                            buf_ctl.data = r_len[63:32];
                            n_phase      = PH_LEN_LO;
                        end else begin
                            buf_ctl.data = '0;
                        end
                    end
                    PH_LEN_LO: begin
                        buf_ctl.data = r_len[31:0];
                        n_phase      = PH_DONE;
                    end
                    default: begin
                        buf_ctl.push = 1'b0;
                    end
                endcase
            end
            S_ROUND: begin
                core_ctl.step = 1'b1;
                buf_ctl.step  = 1'b1;
                n_rnd         = r_rnd + 7'd1;
                if (r_rnd == ROUND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                core_ctl.add = 1'b1;
                if (!r_final) begin
                    n_state = S_IDLE;
                end else if (r_phase == PH_DONE) begin
                    n_state = S_OUT;
                    n_out   = '0;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_OUT: begin
                if (!i_stall) begin
                    if (r_out == OUT_LAST) begin
                        // start a new message
                        core_ctl.init = 1'b1;
                        n_pos         = '0;
                        n_len         = '0;
                        n_final       = 1'b0;
                        n_state       = S_IDLE;
                    end else begin
                        n_out = r_out + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // advance the position; a full block starts the rounds
        if (buf_ctl.push) begin
            n_pos = r_pos + 4'd1;
            if (r_pos == POS_LAST) begin
                n_state       = S_ROUND;
                n_rnd         = '0;
                core_ctl.load = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_len   <= '0;
            r_phase <= PH_PAD;
            r_rnd   <= '0;
            r_out   <= '0;
            r_final <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_phase <= n_phase;
            r_rnd   <= n_rnd;
            r_out   <= n_out;
            r_final <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pad <= n_pad;
    end

`include "sha0_message_digest_assert.svh"

    `SHA0_ASSERT_NOW(a_out_blocks_in, o_valid, o_stall, "input taken while digest pending")
    `SHA0_ASSERT_NOW(a_full_block, r_state == S_ROUND, r_pos == '0, "rounds on partial block")
    `SHA0_ASSERT_NEXT(a_rounds_end, (r_state == S_ROUND) && (r_rnd == ROUND_LAST), r_state == S_ADD, "round count overrun")
    `SHA0_ASSERT_NEXT(a_restart, o_valid && !i_stall && o_run_end, (r_pos == '0) && (r_len == '0) && (r_state == S_IDLE), "no restart after digest")

endmodule

[tb/sha0_message_digest_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-0 message digest testbench
// Streams directed and random messages into the digest block with random
// gaps and output stalls. A behavioral SHA-0 model predicts the five digest
// items of every message, and each delivered item is checked in order.
// ----------------------------------------------------------------------------
module sha0_message_digest_tb;

    localparam int CLK_HALF     = 10;
    localparam int RANDOM_ITEMS = 96;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 400;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int PAUSE_MSG    = 3;

    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [2:0]  FULL_BYTES = 3'd4;
    localparam int          LAST_INDEX = 4;

    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A82_7999, 32'h6ED9_EBA1, 32'h8F1B_BCDC, 32'hCA62_C1D6
    };
    localparam logic [31:0] CHAIN_INIT [5] = '{
        32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  byte_count;
        logic        final_word;
    } t_msg_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        run_end;
    } t_digest_item;

    localparam t_msg_item DIRECTED_ITEMS [22] = '{
        '{32'h0000_0000, 3'd0, 1'b1},   // empty message, pad in first byte
        '{32'hFFFF_FFFF, 3'd0, 1'b1},   // every byte dropped
        '{32'h6162_63FF, 3'd3, 1'b1},   // trailing byte replaced by pad
        '{32'hA5A5_A5A5, 3'd1, 1'b1},
        '{32'h5A5A_5A5A, 3'd2, 1'b1},
        '{32'hFFFF_FFFF, 3'd4, 1'b1},
        '{32'h1234_5678, 3'd5, 1'b1},   // count above four saturates
        '{32'h0000_0000, 3'd7, 1'b1},
        // 13 full words plus a full last word: length spills into a second block
        '{32'hFFFF_FFFF, 3'd0, 1'b0},
        '{32'h0000_0000, 3'd7, 1'b0},
        '{32'h0123_4567, 3'd3, 1'b0},
        '{32'h89AB_CDEF, 3'd1, 1'b0},
        '{32'hDEAD_BEEF, 3'd2, 1'b0},
        '{32'h8000_0001, 3'd4, 1'b0},
        '{32'h7FFF_FFFE, 3'd5, 1'b0},
        '{32'h5555_5555, 3'd6, 1'b0},
        '{32'hAAAA_AAAA, 3'd0, 1'b0},
        '{32'h0F0F_0F0F, 3'd7, 1'b0},
        '{32'hF0F0_F0F0, 3'd4, 1'b0},
        '{32'h3333_CCCC, 3'd2, 1'b0},
        '{32'hCCCC_3333, 3'd1, 1'b0},
        '{32'hFEDC_BA98, 3'd4, 1'b1}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_message_word;
    logic [2:0]  i_byte_count;
    logic        i_final_word;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_number;
    logic        o_run_end;

    // predictor state
    logic [31:0] chain_h [5];
    logic [31:0] block_buf [16];
    logic [3:0]  fill_pos;
    logic [63:0] msg_bits;

    t_digest_item expected_digest [$];
    int unsigned  mismatch_count;
    int unsigned  items_accepted;
    int unsigned  cycle_count;
    bit           hold_off_pending;

    sha0_message_digest DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_byte_count   (i_byte_count),
        .i_final_word   (i_final_word),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_number  (o_word_number),
        .o_run_end      (o_run_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic [31:0] rotl32(logic [31:0] v, int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic void sha0_restart();
        int i;
        for (i = 0; i < 5; i++) chain_h[i] = CHAIN_INIT[i];
        fill_pos = 4'd0;
        msg_bits = 64'd0;
    endfunction

    function automatic void sha0_compress();
        logic [31:0] sched [80];
        logic [31:0] a, b, c, d, e, f, t;
        int i;
        for (i = 0; i < 16; i++) sched[i] = block_buf[i];
        // no rotate in the SHA-0 schedule
        for (i = 16; i < 80; i++)
            sched[i] = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
        a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3]; e = chain_h[4];
        for (i = 0; i < 80; i++) begin
            case (i / 20)
                0: begin
                    f = (b & c) | (~b & d);
                end
                2: begin
                    f = (b & c) | (b & d) | (c & d);
                end
                default: begin
                    f = b ^ c ^ d;
                end
            endcase
            t = rotl32(a, 5) + f + e + sched[i] + ROUND_K[i / 20];
            e = d; d = c; c = rotl32(b, 30); b = a; a = t;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c;
        chain_h[3] += d; chain_h[4] += e;
    endfunction

    function automatic void sha0_absorb_word(logic [31:0] v);
        block_buf[fill_pos] = v;
        fill_pos = fill_pos + 4'd1;
        if (fill_pos == 4'd0) sha0_compress();
    endfunction

    function automatic void sha0_take_item(t_msg_item it);
        logic [2:0]   n;
        logic [31:0]  keep, padded;
        t_digest_item r;
        int i;
        if (!it.final_word) begin
            msg_bits = msg_bits + 64'd32;
            sha0_absorb_word(it.word);
            return;
        end
        n = (it.byte_count > FULL_BYTES) ? FULL_BYTES : it.byte_count;
        msg_bits = msg_bits + {58'd0, n, 3'b000};
        if (n == FULL_BYTES) begin
            sha0_absorb_word(it.word);
            padded = PAD_WORD;
        end else begin
            keep = (n == 3'd0) ? 32'h0 : ~(32'hFFFF_FFFF >> (8 * n));
            padded = (it.word & keep) | (PAD_WORD >> (8 * n));
        end
        sha0_absorb_word(padded);
        // no room for the length: close this block with zeros
        if (fill_pos > 4'd14) begin
            while (fill_pos != 4'd0) sha0_absorb_word(32'h0);
        end
        while (fill_pos < 4'd14) sha0_absorb_word(32'h0);
        sha0_absorb_word(msg_bits[63:32]);
        sha0_absorb_word(msg_bits[31:0]);
        for (i = 0; i < 5; i++) begin
            r.digest_word = chain_h[i];
            r.word_number = 3'(i);
            r.run_end     = (i == LAST_INDEX);
            expected_digest.push_back(r);
        end
        sha0_restart();
    endfunction

    function automatic logic [31:0] pick_word();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 32'h0;
        if (roll == 1) return 32'hFFFF_FFFF;
        return $urandom();
    endfunction

    function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("digest %s mismatch: expected %h, got %h", field, want, got);
        end
    endfunction

    task automatic check_digest_item();
        t_digest_item want;
        if (expected_digest.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected digest item: word %h number %0d run_end %0b",
                         o_digest_word, o_word_number, o_run_end);
        end else begin
            want = expected_digest.pop_front();
            compare_field("digest_word", want.digest_word, o_digest_word);
            compare_field("word_number", 32'(want.word_number), 32'(o_word_number));
            compare_field("run_end", 32'(want.run_end), 32'(o_run_end));
        end
    endtask

    task automatic offer_item(input t_msg_item it);
        i_valid        <= 1'b1;
        i_message_word <= it.word;
        i_byte_count   <= it.byte_count;
        i_final_word   <= it.final_word;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sha0_take_item(it);
        items_accepted++;
    endtask

    task automatic sender_idle(input bit steady);
        int unsigned roll, gap;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) gap = 0;
        else if (roll < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(20, 60);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output side: random stall runs, one long hold-off on request
    initial begin
        int unsigned run_left, hold_left, roll;
        logic        run_stall;
        i_stall <= 1'b0;
        run_left  = 0;
        hold_left = 0;
        run_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_digest_item();
            if (hold_left == 0 && hold_off_pending) begin
                hold_left = HOLD_CYCLES;
                hold_off_pending = 1'b0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 50) begin
                        run_stall = 1'b0; run_left = $urandom_range(1, 8);
                    end else if (roll < 60) begin
                        run_stall = 1'b0; run_left = $urandom_range(40, 150);
                    end else if (roll < 96) begin
                        run_stall = 1'b1; run_left = $urandom_range(1, 3);
                    end else begin
                        run_stall = 1'b1; run_left = $urandom_range(15, 60);
                    end
                end
                run_left--;
                i_stall <= run_stall;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_msg_item   it;
        int unsigned n_words, msg_index, random_start;
        bit          steady;
        int          row;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_message_word <= 32'h0;
        i_byte_count   <= 3'd0;
        i_final_word   <= 1'b0;
        mismatch_count   = 0;
        items_accepted   = 0;
        hold_off_pending = 1'b0;
        sha0_restart();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < $size(DIRECTED_ITEMS); row++) begin
            offer_item(DIRECTED_ITEMS[row]);
            sender_idle(1'b0);
        end

        // stall the output early while words keep coming, so the block backs up
        hold_off_pending = 1'b1;
        msg_index    = 0;
        random_start = items_accepted;
        while (items_accepted - random_start < RANDOM_ITEMS) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0) n_words = $urandom_range(17, 40);
            else n_words = $urandom_range(0, 16);
            repeat (n_words) begin
                it.word       = pick_word();
                it.byte_count = 3'($urandom_range(0, 7));
                it.final_word = 1'b0;
                offer_item(it);
                sender_idle(steady);
            end
            it.word       = pick_word();
            it.byte_count = 3'($urandom_range(0, 7));
            it.final_word = 1'b1;
            offer_item(it);
            if (msg_index == PAUSE_MSG) begin
                // hold the input until the whole digest is out
                i_valid <= 1'b0;
                while (expected_digest.size() != 0) @(posedge i_clk);
            end else begin
                sender_idle(steady);
            end
            msg_index++;
        end
        i_valid <= 1'b0;

        while (expected_digest.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
